/* src/nssc_pkg.sv */
// Shared types, character codes and helper functions for the NMEA sentence
// splitter and checker. No dependencies.
package nssc_pkg;

  // Default capacities, handed to the top-level parameters.
  localparam int MAX_FIELDS_DEF  = 32;
  localparam int FIELD_CHARS_DEF = 32;

  // Fixed widths of the port fields.
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 5;
  localparam int TYPE_W = 3;
  localparam int HDR_W  = 24;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;

  // Three-letter sentence identifiers as they sit in the header window.
  localparam logic [HDR_W-1:0] HDR_GGA = 24'h474741;
  localparam logic [HDR_W-1:0] HDR_GSV = 24'h475356;
  localparam logic [HDR_W-1:0] HDR_RMC = 24'h524D43;
  localparam logic [HDR_W-1:0] HDR_GSA = 24'h475341;

  // Sentence type codes.
  localparam logic [TYPE_W-1:0] TYPE_UNKNOWN = 3'd0;
  localparam logic [TYPE_W-1:0] TYPE_GGA     = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_GSV     = 3'd2;
  localparam logic [TYPE_W-1:0] TYPE_RMC     = 3'd3;
  localparam logic [TYPE_W-1:0] TYPE_GSA     = 3'd4;

  // One result word.
  typedef struct packed {
    logic [CHAR_W-1:0] data_char;
    logic              char_valid;
    logic [IDX_W-1:0]  field_index;
    logic [IDX_W-1:0]  char_index;
    logic              field_end;
    logic              sentence_end;
    logic              checksum_ok;
    logic [TYPE_W-1:0] sentence_type;
    logic [CHAR_W-1:0] computed_sum;
    logic [CHAR_W-1:0] received_sum;
    logic              overflow_flag;
  } res_t;

  // Decodes an ASCII hex digit of either case. Bit 4 flags a valid digit.
  function automatic logic [4:0] hex_decode(input logic [CHAR_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  // Maps the last three header characters to a sentence type.
  function automatic logic [TYPE_W-1:0] match_header(input logic [HDR_W-1:0] w);
    logic [TYPE_W-1:0] t;
    t = TYPE_UNKNOWN;
    priority if (w == HDR_GGA) begin
      t = TYPE_GGA;
    end else if (w == HDR_GSV) begin
      t = TYPE_GSV;
    end else if (w == HDR_RMC) begin
      t = TYPE_RMC;
    end else if (w == HDR_GSA) begin
      t = TYPE_GSA;
    end else begin
      t = TYPE_UNKNOWN;
    end
    return t;
  endfunction

endpackage

/* src/nmea_sentence_splitter_checker.sv */
// Top level of the NMEA sentence splitter and checker.
// Depends on nssc_pkg for character codes, the result word type and decoders.

// The block takes an NMEA 0183 byte stream, one byte per word on the input
// channel, and returns exactly one result word for every byte accepted. A '$'
// opens a sentence and clears all sentence state; bytes up to '*' are XORed
// into the computed checksum (CR and LF excluded), and commas split the
// payload into fields. Each stored payload byte comes out with char_valid set
// and its field and character positions. Field 0 is scanned for GGA, GSV, RMC
// or GSA; when several appear, the lowest type code wins. Hex digits after '*'
// shift into the received checksum, of which the low byte is kept. CR or LF
// closes an open sentence with sentence_end, and checksum_ok is set only if a
// '*' was seen and both sums agree. A comma in the last field index keeps the
// index and sets overflow_flag, as does a payload byte past FIELD_CHARS; such
// a byte is still summed but not stored. Indices are reported modulo 32.
// Throughput is one byte per clock cycle while in_stall is low: all per-byte
// work is a handful of compares and an XOR, done in the cycle the byte is
// accepted, and the result word is then registered on the output side. The
// output side has a result register backed by one skid register, so a byte is still accepted
// while one result waits to be taken; in_stall rises only when both are full.
module nmea_sentence_splitter_checker #(
  parameter int MAX_FIELDS  = nssc_pkg::MAX_FIELDS_DEF,
  parameter int FIELD_CHARS = nssc_pkg::FIELD_CHARS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [nssc_pkg::CHAR_W-1:0]   char_in,
  // Output channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [nssc_pkg::CHAR_W-1:0]   data_char,
  output logic                          char_valid,
  output logic [nssc_pkg::IDX_W-1:0]    field_index,
  output logic [nssc_pkg::IDX_W-1:0]    char_index,
  output logic                          field_end,
  output logic                          sentence_end,
  output logic                          checksum_ok,
  output logic [nssc_pkg::TYPE_W-1:0]   sentence_type,
  output logic [nssc_pkg::CHAR_W-1:0]   computed_sum,
  output logic [nssc_pkg::CHAR_W-1:0]   received_sum,
  output logic                          overflow_flag
);

  import nssc_pkg::*;

  // Field count runs to MAX_FIELDS-1; char count must also hold FIELD_CHARS.
  localparam int FC_W = $clog2(MAX_FIELDS);
  localparam int CC_W = $clog2(FIELD_CHARS + 1);
  localparam logic [FC_W-1:0] FIELD_LAST = FC_W'(MAX_FIELDS - 1);
  localparam logic [CC_W-1:0] CHAR_LIMIT = CC_W'(FIELD_CHARS);

  // Sentence state.
  logic              in_sentence, in_sentence_next;
  logic              after_star, after_star_next;
  logic [CHAR_W-1:0] running_xor, running_xor_next;
  logic [CHAR_W-1:0] hex_accum, hex_accum_next;
  logic [FC_W-1:0]   field_count, field_count_next;
  logic [CC_W-1:0]   char_count, char_count_next;
  logic [HDR_W-1:0]  header_window, header_window_next;
  logic [TYPE_W-1:0] type_found, type_found_next;
  logic              overflow_seen, overflow_seen_next;

  // Output buffering: result register plus one skid register.
  res_t out_res;
  res_t skid_res;
  logic skid_valid;

  res_t res;
  logic in_accept;
  logic out_take;

  logic [4:0]        hex_dig;
  logic [HDR_W-1:0]  window_shift;
  logic [TYPE_W-1:0] hdr_type;
  logic              stored;
  logic [FC_W-1:0]   fi_sel;
  logic [CC_W-1:0]   ci_sel;
  logic [31:0]       fi_ext;
  logic [31:0]       ci_ext;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  assign hex_dig      = hex_decode(char_in);
  assign window_shift = {header_window[HDR_W-CHAR_W-1:0], char_in};
  assign hdr_type     = match_header(window_shift);

  // Next state and the result word for the byte on char_in.
  always_comb begin
    in_sentence_next   = in_sentence;
    after_star_next    = after_star;
    running_xor_next   = running_xor;
    hex_accum_next     = hex_accum;
    field_count_next   = field_count;
    char_count_next    = char_count;
    header_window_next = header_window;
    type_found_next    = type_found;
    overflow_seen_next = overflow_seen;
    stored             = 1'b0;

    res               = '0;
    res.data_char     = char_in;

    priority if (char_in == CH_DOLLAR) begin
      in_sentence_next   = 1'b1;
      after_star_next    = 1'b0;
      running_xor_next   = '0;
      hex_accum_next     = '0;
      field_count_next   = '0;
      char_count_next    = '0;
      header_window_next = '0;
      type_found_next    = TYPE_UNKNOWN;
      overflow_seen_next = 1'b0;
    end else if (!in_sentence) begin
      // Bytes between sentences change nothing.
    end else if (char_in == CH_CR || char_in == CH_LF) begin
      res.sentence_end = 1'b1;
      res.checksum_ok  = after_star && (hex_accum == running_xor);
      in_sentence_next = 1'b0;
    end else if (after_star) begin
      if (hex_dig[4]) begin
        hex_accum_next = {hex_accum[3:0], hex_dig[3:0]};
      end
    end else if (char_in == CH_STAR) begin
      after_star_next = 1'b1;
      res.field_end   = 1'b1;
    end else if (char_in == CH_COMMA) begin
      running_xor_next = running_xor ^ char_in;
      res.field_end    = 1'b1;
      if (field_count != FIELD_LAST) begin
        field_count_next = field_count + 1'b1;
      end else begin
        overflow_seen_next = 1'b1;
      end
      char_count_next = '0;
    end else begin
      running_xor_next = running_xor ^ char_in;
      if (char_count < CHAR_LIMIT) begin
        stored          = 1'b1;
        char_count_next = char_count + 1'b1;
        if (field_count == '0) begin
          header_window_next = window_shift;
          if (hdr_type != TYPE_UNKNOWN &&
              (type_found == TYPE_UNKNOWN || hdr_type < type_found)) begin
            type_found_next = hdr_type;
          end
        end
      end else begin
        overflow_seen_next = 1'b1;
      end
    end

    // A stored byte reports its own position; anything else the counts after it.
    fi_sel = stored ? field_count : field_count_next;
    ci_sel = stored ? char_count : char_count_next;
    fi_ext = 32'(fi_sel);
    ci_ext = 32'(ci_sel);

    res.char_valid    = stored;
    res.field_index   = fi_ext[IDX_W-1:0];
    res.char_index    = ci_ext[IDX_W-1:0];
    res.sentence_type = type_found_next;
    res.computed_sum  = running_xor_next;
    res.received_sum  = hex_accum_next;
    res.overflow_flag = overflow_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence   <= 1'b0;
      after_star    <= 1'b0;
      running_xor   <= '0;
      hex_accum     <= '0;
      field_count   <= '0;
      char_count    <= '0;
      header_window <= '0;
      type_found    <= TYPE_UNKNOWN;
      overflow_seen <= 1'b0;
    end else if (in_accept) begin
      in_sentence   <= in_sentence_next;
      after_star    <= after_star_next;
      running_xor   <= running_xor_next;
      hex_accum     <= hex_accum_next;
      field_count   <= field_count_next;
      char_count    <= char_count_next;
      header_window <= header_window_next;
      type_found    <= type_found_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  // Output control. The result register takes a new word when it is empty
  // or being emptied; otherwise the word parks in the skid register. While
  // the skid register is full no byte is accepted, so it drains first.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) begin
          skid_valid <= 1'b0;
        end
      end else if (in_accept) begin
        if (!out_valid || out_take) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_res <= skid_res;
      end
    end else if (in_accept) begin
      if (!out_valid || out_take) begin
        out_res <= res;
      end else begin
        skid_res <= res;
      end
    end
  end

  assign data_char     = out_res.data_char;
  assign char_valid    = out_res.char_valid;
  assign field_index   = out_res.field_index;
  assign char_index    = out_res.char_index;
  assign field_end     = out_res.field_end;
  assign sentence_end  = out_res.sentence_end;
  assign checksum_ok   = out_res.checksum_ok;
  assign sentence_type = out_res.sentence_type;
  assign computed_sum  = out_res.computed_sum;
  assign received_sum  = out_res.received_sum;
  assign overflow_flag = out_res.overflow_flag;

endmodule
